FILE: src/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/srht_pkg.sv
package srht_pkg;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_ROUTE = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic init;
        logic scan_step;
        logic pick;
        logic relax_step;
        logic path_step;
        logic emit_none;
    } srht_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic query_bad;
        logic scan_last;
        logic have;
        logic u_is_dst;
        logic relax_last;
        logic at_src;
    } srht_status_t;

endpackage

FILE: src/shortest_route_hop_tiebreak_unit.sv
// Shortest route unit. After reset the edge matrix is cleared, one entry per cycle, with busy
// high. An edge write does not raise busy. A route query runs one round per settled
// vertex: a scan of all vertices, a pick step and a relaxation sweep over the matrix row
// (one edge-memory read per cycle), then one result per path vertex on consecutive cycles,
// destination first. A query with an out-of-range or equal endpoint, or with no path, gives
// a single result with found low. Results appear on done for exactly one cycle each
// and cannot be stalled; the final one has last set and busy drops with it.
`include "assert_macros.svh"

module shortest_route_hop_tiebreak_unit
    import srht_pkg::*;
#(
    parameter int VERTICES  = 16,
    parameter int COST_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [3:0]  src_vertex,
    input  logic [3:0]  dst_vertex,
    input  logic [15:0] edge_cost,
    output logic        done,
    output logic        found,
    output logic [3:0]  route_vertex,
    output logic [19:0] route_cost,
    output logic [3:0]  hop_count,
    output logic        last
);

    srht_cmd_t    cmd;
    srht_status_t status;
    logic         accept;

    // transaction accepted when idle
    assign accept = start && !busy;

    srht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    srht_dp #(
        .VERTICES  (VERTICES),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req_type),
        .src_vertex   (src_vertex),
        .dst_vertex   (dst_vertex),
        .edge_cost    (edge_cost),
        .cmd          (cmd),
        .status       (status),
        .done         (done),
        .found        (found),
        .route_vertex (route_vertex),
        .route_cost   (route_cost),
        .hop_count    (hop_count),
        .last         (last)
    );

    // result stream checks
    `ASSERT_SAME(a_none_is_last, clk, rst_n, done && !found, last)
    `ASSERT_NEXT(a_path_contiguous, clk, rst_n, done && !last, done)
    `ASSERT_NEXT(a_last_ends_run, clk, rst_n, done && last, !done)

endmodule

FILE: src/srht_ctrl.sv
module srht_ctrl
    import srht_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic         req_type,
    input  srht_status_t status,
    output srht_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_PICK,
        S_RELAX,
        S_PATH,
        S_NONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept && (req_type == REQ_ROUTE))
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = status.query_bad ? S_NONE : S_SCAN;
            end
            S_SCAN:
            begin
                if (status.scan_last)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                if (!status.have)
                    state_next = S_NONE;
                else if (status.u_is_dst)
                    state_next = S_PATH;
                else
                    state_next = S_RELAX;
            end
            S_RELAX:
            begin
                if (status.relax_last)
                    state_next = S_SCAN;
            end
            S_PATH:
            begin
                if (status.at_src)
                    state_next = S_IDLE;
            end
            S_NONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command decode
    always_comb
    begin
        cmd            = '0;
        cmd.clear_step = (state_reg == S_CLEAR);
        cmd.init       = (state_reg == S_CHECK) && !status.query_bad;
        cmd.scan_step  = (state_reg == S_SCAN);
        cmd.pick       = (state_reg == S_PICK);
        cmd.relax_step = (state_reg == S_RELAX);
        cmd.path_step  = (state_reg == S_PATH);
        cmd.emit_none  = (state_reg == S_NONE);
    end

    // state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

FILE: src/srht_dp.sv
module srht_dp
    import srht_pkg::*;
#(
    parameter int VERTICES  = 16,
    parameter int COST_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic         req_type,
    input  logic [3:0]   src_vertex,
    input  logic [3:0]   dst_vertex,
    input  logic [15:0]  edge_cost,
    input  srht_cmd_t    cmd,
    output srht_status_t status,
    output logic         done,
    output logic         found,
    output logic [3:0]   route_vertex,
    output logic [19:0]  route_cost,
    output logic [3:0]   hop_count,
    output logic         last
);

    localparam int VW    = $clog2(VERTICES);
    localparam int CW    = COST_BITS + VW;
    localparam int HW    = VW + 1;
    localparam int KW    = VW + 1;
    localparam int DEPTH = VERTICES * VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [32:0] CAP = (33'd1 << COST_BITS) - 33'd1;

    // edge matrix and per-vertex search state
    logic [COST_BITS-1:0] edge_mem [DEPTH];
    logic [CW-1:0]        cost_mem [VERTICES];
    logic [HW-1:0]        hops_mem [VERTICES];
    logic [VW-1:0]        pred_mem [VERTICES];

    logic [VW-1:0]        src_reg, dst_reg;
    logic                 qbad_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic [VW-1:0]        scan_i_reg;
    logic [KW-1:0]        relax_k_reg;
    logic [VW-1:0]        cur_reg, u_reg, bu_reg;
    logic [CW-1:0]        ucost_reg, bcost_reg;
    logic [HW-1:0]        uhops_reg, bhops_reg;
    logic                 bhave_reg;
    logic [VERTICES-1:0]  reached_reg, settled_reg;
    logic [COST_BITS-1:0] edge_q_reg;
    logic                 done_reg, found_reg, last_reg;
    logic [3:0]           vertex_reg, hops_out_reg;
    logic [19:0]          cost_out_reg;

    logic                 src_ok, dst_ok, edge_wr;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [COST_BITS-1:0] w_sat;
    logic [VW-1:0]        rd_idx, v_d, k_idx;
    logic [CW-1:0]        rd_cost, nc;
    logic [HW-1:0]        rd_hops, nh;
    logic [VW-1:0]        rd_pred;
    logic                 cand, have_eff, better, relax_act, upd;
    logic                 vwr_en;
    logic [VW-1:0]        vwr_idx;
    logic [CW-1:0]        vwr_cost;
    logic [HW-1:0]        vwr_hops;

    // request decode
    assign src_ok  = ({28'd0, src_vertex} < VERTICES);
    assign dst_ok  = ({28'd0, dst_vertex} < VERTICES);
    assign edge_wr = accept && (req_type == REQ_WRITE) && src_ok && dst_ok;
    assign w_sat   = ({17'd0, edge_cost} > CAP) ? CAP[COST_BITS-1:0]
                                                : COST_BITS'(edge_cost);
    assign wr_addr = AW'(AW'(VW'(src_vertex)) * AW'(VERTICES) + AW'(VW'(dst_vertex)));

    // edge read address for relaxation
    assign k_idx   = status.relax_last ? '0 : relax_k_reg[VW-1:0];
    assign rd_addr = AW'(AW'(u_reg) * AW'(VERTICES) + AW'(k_idx));
    assign v_d     = VW'(relax_k_reg - KW'(1));

    // edge memory: clearing pass, writes, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            edge_mem[clr_cnt_reg] <= '0;
        else if (edge_wr)
            edge_mem[wr_addr] <= w_sat;
        edge_q_reg <= edge_mem[rd_addr];
    end

    // single vertex read port
    always_comb
    begin
        case (1'b1)
            cmd.relax_step: rd_idx = v_d;
            cmd.path_step:  rd_idx = cur_reg;
            default:        rd_idx = scan_i_reg;
        endcase
    end

    assign rd_cost = cost_mem[rd_idx];
    assign rd_hops = hops_mem[rd_idx];
    assign rd_pred = pred_mem[rd_idx];

    // minimum scan compare
    assign cand     = reached_reg[scan_i_reg] && !settled_reg[scan_i_reg];
    assign have_eff = (scan_i_reg != '0) && bhave_reg;
    assign better   = cand && (!have_eff || (rd_cost < bcost_reg) ||
                      ((rd_cost == bcost_reg) && (rd_hops < bhops_reg)));

    // relaxation compare
    assign relax_act = cmd.relax_step && (relax_k_reg != '0);
    assign nc        = ucost_reg + CW'(edge_q_reg);
    assign nh        = uhops_reg + HW'(1);
    assign upd       = relax_act && (edge_q_reg != '0) &&
                       (!reached_reg[v_d] || (nc < rd_cost) ||
                       ((nc == rd_cost) && (nh < rd_hops)));

    // vertex state write port
    always_comb
    begin
        vwr_en   = 1'b0;
        vwr_idx  = v_d;
        vwr_cost = nc;
        vwr_hops = nh;
        if (cmd.init)
        begin
            vwr_en   = 1'b1;
            vwr_idx  = src_reg;
            vwr_cost = '0;
            vwr_hops = '0;
        end
        else if (upd)
        begin
            vwr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            cost_mem[vwr_idx] <= vwr_cost;
            hops_mem[vwr_idx] <= vwr_hops;
        end
        if (upd)
            pred_mem[v_d] <= u_reg;
    end

    // request capture and search payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg  <= VW'(src_vertex);
            dst_reg  <= VW'(dst_vertex);
            qbad_reg <= !src_ok || !dst_ok || (src_vertex == dst_vertex);
        end
        if (cmd.scan_step && better)
        begin
            bu_reg    <= scan_i_reg;
            bcost_reg <= rd_cost;
            bhops_reg <= rd_hops;
        end
        if (cmd.pick)
        begin
            u_reg     <= bu_reg;
            ucost_reg <= bcost_reg;
            uhops_reg <= bhops_reg;
            cur_reg   <= dst_reg;
        end
        else if (cmd.path_step)
        begin
            cur_reg <= rd_pred;
        end
        if (cmd.path_step)
        begin
            found_reg    <= 1'b1;
            vertex_reg   <= 4'(cur_reg);
            cost_out_reg <= 20'(ucost_reg);
            hops_out_reg <= 4'(uhops_reg);
            last_reg     <= (cur_reg == src_reg);
        end
        else if (cmd.emit_none)
        begin
            found_reg    <= 1'b0;
            vertex_reg   <= '0;
            cost_out_reg <= '0;
            hops_out_reg <= '0;
            last_reg     <= 1'b1;
        end
    end

    // control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            scan_i_reg  <= '0;
            relax_k_reg <= '0;
            bhave_reg   <= 1'b0;
            reached_reg <= '0;
            settled_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.path_step || cmd.emit_none;
            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cmd.init)
            begin
                reached_reg <= VERTICES'(1) << src_reg;
                settled_reg <= '0;
                scan_i_reg  <= '0;
            end
            if (cmd.scan_step)
            begin
                scan_i_reg <= scan_i_reg + VW'(1);
                if (better)
                    bhave_reg <= 1'b1;
                else if (scan_i_reg == '0)
                    bhave_reg <= 1'b0;
            end
            if (cmd.pick)
            begin
                scan_i_reg  <= '0;
                relax_k_reg <= '0;
                if (bhave_reg)
                    settled_reg[bu_reg] <= 1'b1;
            end
            if (cmd.relax_step)
                relax_k_reg <= relax_k_reg + KW'(1);
            if (upd)
                reached_reg[v_d] <= 1'b1;
        end
    end

    // status to controller
    always_comb
    begin
        status            = '0;
        status.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
        status.query_bad  = qbad_reg;
        status.scan_last  = (scan_i_reg == VW'(VERTICES - 1));
        status.have       = bhave_reg;
        status.u_is_dst   = (bu_reg == dst_reg);
        status.relax_last = (relax_k_reg == KW'(VERTICES));
        status.at_src     = (cur_reg == src_reg);
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign route_vertex = vertex_reg;
    assign route_cost   = cost_out_reg;
    assign hop_count    = hops_out_reg;
    assign last         = last_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb
    import srht_pkg::*;
();

    localparam int NV = 16;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        logic        req_type;
        logic [3:0]  src_vertex;
        logic [3:0]  dst_vertex;
        logic [15:0] edge_cost;
    } route_req_t;

    typedef struct {
        logic        found;
        logic [3:0]  route_vertex;
        logic [19:0] route_cost;
        logic [3:0]  hop_count;
        logic        last;
    } route_hop_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [3:0]  src_vertex;
    logic [3:0]  dst_vertex;
    logic [15:0] edge_cost;
    logic        done;
    logic        found;
    logic [3:0]  route_vertex;
    logic [19:0] route_cost;
    logic [3:0]  hop_count;
    logic        last;

    route_req_t  pending_reqs[$];
    route_hop_t  expected_hops[$];
    logic [15:0] graph_w[NV][NV] = '{default: '0};
    int          error_count = 0;
    int          cycle_count = 0;
    int          gap_left;
    bit          quiet_mode;

    shortest_route_hop_tiebreak_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .src_vertex(src_vertex), .dst_vertex(dst_vertex),
        .edge_cost(edge_cost), .done(done), .found(found),
        .route_vertex(route_vertex), .route_cost(route_cost),
        .hop_count(hop_count), .last(last)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // dijkstra with cost, hops, index tie-break; queues the expected path or a not-found result
    task automatic predict_route(input route_req_t rq);
        logic [20:0] cost_v[NV];
        logic [4:0]  hops[NV];
        logic [3:0]  prev[NV];
        bit          seen[NV];
        bit          done_v[NV];
        bit          have;
        int          u;
        int          cur;
        logic [20:0] nc;
        logic [4:0]  nh;
        route_hop_t  h;
        if (rq.src_vertex == rq.dst_vertex)
        begin
            h = '{1'b0, 4'd0, 20'd0, 4'd0, 1'b1};
            expected_hops = {expected_hops, h};
            return;
        end
        for (int i = 0; i < NV; i++)
        begin
            cost_v[i] = '0; hops[i] = '0; prev[i] = '0; seen[i] = 0; done_v[i] = 0;
        end
        seen[rq.src_vertex] = 1;
        for (int r = 0; r < NV; r++)
        begin
            have = 0;
            u = 0;
            for (int i = 0; i < NV; i++)
            begin
                if (seen[i] && !done_v[i])
                    if (!have || cost_v[i] < cost_v[u] ||
                        (cost_v[i] == cost_v[u] && hops[i] < hops[u]))
                    begin
                        u = i;
                        have = 1;
                    end
            end
            if (!have)
                break;
            done_v[u] = 1;
            if (u == rq.dst_vertex)
                break;
            for (int v = 0; v < NV; v++)
            begin
                if (graph_w[u][v] == 0)
                    continue;
                nc = cost_v[u] + graph_w[u][v];
                nh = hops[u] + 5'd1;
                if (seen[v] && (nc > cost_v[v] || (nc == cost_v[v] && nh >= hops[v])))
                    continue;
                seen[v] = 1;
                cost_v[v] = nc;
                hops[v] = nh;
                prev[v] = u[3:0];
            end
        end
        if (!seen[rq.dst_vertex])
        begin
            h = '{1'b0, 4'd0, 20'd0, 4'd0, 1'b1};
            expected_hops = {expected_hops, h};
            return;
        end
        cur = rq.dst_vertex;
        for (int n = 0; n < NV; n++)
        begin
            h.found = 1'b1;
            h.route_vertex = cur[3:0];
            h.route_cost = cost_v[rq.dst_vertex][19:0];
            h.hop_count = hops[rq.dst_vertex][3:0];
            h.last = (cur == rq.src_vertex);
            expected_hops = {expected_hops, h};
            if (h.last)
                break;
            cur = prev[cur];
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        route_req_t rq;
        if (!rst_n)
        begin
            start <= 1'b0;
            req_type <= 1'b0;
            src_vertex <= '0;
            dst_vertex <= '0;
            edge_cost <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                rq = pending_reqs.pop_front();
                if (rq.req_type == REQ_WRITE)
                    graph_w[rq.src_vertex][rq.dst_vertex] = rq.edge_cost;
                else
                    predict_route(rq);
            end
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() > 0 && !quiet_mode && $urandom_range(0, 5) == 0
                     && !(start && !busy))
            begin
                start <= 1'b0;
                gap_left <= $urandom_range(1, 10) - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                rq = pending_reqs[0];
                start <= 1'b1;
                req_type <= rq.req_type;
                src_vertex <= rq.src_vertex;
                dst_vertex <= rq.dst_vertex;
                edge_cost <= rq.edge_cost;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        route_hop_t exp_h;
        if (rst_n && done)
        begin
            if (expected_hops.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                exp_h = expected_hops.pop_front();
                if (found !== exp_h.found)
                    report_mismatch($sformatf("found %b exp %b", found, exp_h.found));
                if (route_vertex !== exp_h.route_vertex)
                    report_mismatch($sformatf("route_vertex %0d exp %0d",
                                              route_vertex, exp_h.route_vertex));
                if (route_cost !== exp_h.route_cost)
                    report_mismatch($sformatf("route_cost %0d exp %0d",
                                              route_cost, exp_h.route_cost));
                if (hop_count !== exp_h.hop_count)
                    report_mismatch($sformatf("hop_count %0d exp %0d",
                                              hop_count, exp_h.hop_count));
                if (last !== exp_h.last)
                    report_mismatch($sformatf("last %b exp %b", last, exp_h.last));
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_req(input logic t, input int s, input int d, input int w);
        route_req_t rq;
        rq.req_type = t;
        rq.src_vertex = s[3:0];
        rq.dst_vertex = d[3:0];
        rq.edge_cost = w[15:0];
        pending_reqs = {pending_reqs, rq};
    endtask

    // stimulus
    initial
    begin
        int k;
        int span;
        quiet_mode = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty graph, same endpoints, chain, ties, heavy weights, self loop
        add_req(REQ_ROUTE, 0, 15, 16'hffff);
        add_req(REQ_ROUTE, 5, 5, 0);
        add_req(REQ_WRITE, 0, 1, 1);
        add_req(REQ_WRITE, 1, 2, 1);
        add_req(REQ_WRITE, 0, 2, 2);
        add_req(REQ_ROUTE, 0, 2, 0);
        add_req(REQ_WRITE, 3, 3, 7);
        add_req(REQ_WRITE, 2, 3, 16'hffff);
        add_req(REQ_ROUTE, 0, 3, 0);
        add_req(REQ_ROUTE, 3, 0, 0);
        add_req(REQ_WRITE, 0, 2, 0);
        add_req(REQ_ROUTE, 0, 2, 0);
        for (int i = 3; i < 15; i++)
            add_req(REQ_WRITE, i, i + 1, 16'hffff);
        add_req(REQ_ROUTE, 0, 15, 0);
        add_req(REQ_ROUTE, 15, 15, 16'hffff);

        // random: mostly writes building a graph, queries between them
        for (int n = 0; n < 205; n++)
        begin
            k = $urandom_range(0, 9);
            span = $urandom_range(0, 3);
            if (k < 6)
                add_req(REQ_WRITE, $urandom_range(0, 15),
                        span == 0 ? $urandom_range(0, 15) : $urandom_range(0, 15),
                        span == 0 ? 0 : (span == 1 ? $urandom_range(0, 65535)
                                                   : $urandom_range(1, 40)));
            else
                add_req(REQ_ROUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 65535));
            if (n == 170)
            begin
                while (pending_reqs.size() > 0)
                    @(posedge clk);
                quiet_mode = 1;
            end
        end

        while (pending_reqs.size() > 0 || expected_hops.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: shortest_route_hop_tiebreak_unit.f
+incdir+src
src/srht_pkg.sv
src/srht_ctrl.sv
src/srht_dp.sv
src/shortest_route_hop_tiebreak_unit.sv
verif/tb.sv
